// File: rtl/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types, constants and the control store of the neuron core.
// ----------------------------------------------------------------------------
package lif_pkg;

  localparam int PC_W = 5;

  // reset values of the registers and of the membrane, Q8.24
  localparam logic signed [31:0] LEAK_RESET      = -32'sd1258291;
  localparam logic signed [31:0] VRESET_RESET    = -32'sd1342177;
  localparam logic signed [31:0] THRESHOLD_RESET = -32'sd922747;
  localparam logic signed [31:0] SPIKE_RESET     = 32'sd167772;
  localparam logic [23:0]        STEP_RESET      = 24'd167772;
  localparam logic [31:0]        SCALE_RESET     = 32'd1678;
  localparam logic signed [31:0] DRIVE_RESET     = 32'sd0;
  localparam logic signed [31:0] MEMBRANE_RESET  = -32'sd1258291;

  typedef enum logic [2:0] {
    CFG_LEAK, CFG_RESET, CFG_THRESHOLD, CFG_SPIKE, CFG_STEP, CFG_SCALE, CFG_DRIVE
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] leak_potential;
    logic signed [31:0] reset_potential;
    logic signed [31:0] threshold_potential;
    logic signed [31:0] spike_potential;
    logic [23:0]        step_ratio;
    logic [31:0]        synapse_scale;
    logic signed [31:0] drive_voltage;
  } cfg_t;

  typedef struct packed {
    logic               fired;
    logic signed [31:0] membrane_potential;
    logic [31:0]        tick_count;
  } res_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE, MUL_SCALE_G, MUL_MAG_LO, MUL_MAG_HI, MUL_TOT_LO, MUL_TOT_HI
  } mul_sel_t;

  // what happens with the registered product
  typedef enum logic [2:0] {
    ACC_NONE, ACC_COEF, ACC_LOAD_LO, ACC_ADD, ACC_ADD_HI
  } acc_op_t;

  // sign/magnitude conversions
  typedef enum logic [1:0] {
    SGN_NONE, SGN_ABS, SGN_APPLY
  } sgn_op_t;

  typedef enum logic [1:0] {
    A_TMP, A_VREV, A_LEAK
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ZERO, B_NVEFF, B_VEFF, B_SUM, B_DRIVE
  } b_sel_t;

  typedef enum logic [1:0] {
    DST_NONE, DST_TMP, DST_SUM
  } dst_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_END_IF_MID, SEQ_END
  } seq_t;

  typedef struct packed {
    logic     veff_ld;
    mul_sel_t mul;
    acc_op_t  acc;
    sgn_op_t  sgn;
    a_sel_t   a;
    b_sel_t   b;
    logic     sat;
    dst_t     dst;
    seq_t     seq;
    logic     emit;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{
    veff_ld: 1'b0, mul: MUL_NONE, acc: ACC_NONE, sgn: SGN_NONE, a: A_TMP,
    b: B_ZERO, sat: 1'b0, dst: DST_NONE, seq: SEQ_END, emit: 1'b0
  };

  // control store: steps 0..8 handle one synapse, 9..18 the end of a tick
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c     = CTRL_IDLE;
    c.seq = SEQ_NEXT;
    case (pc)
      5'd0: begin
        c.veff_ld = 1'b1;
        c.mul     = MUL_SCALE_G;
      end
      5'd1: begin
        c.acc = ACC_COEF;
        c.a   = A_VREV;
        c.b   = B_NVEFF;
        c.sat = 1'b1;
        c.dst = DST_TMP;
      end
      5'd2: c.sgn = SGN_ABS;
      5'd3: c.mul = MUL_MAG_LO;
      5'd4: begin
        c.acc = ACC_LOAD_LO;
        c.mul = MUL_MAG_HI;
      end
      5'd5: c.acc = ACC_ADD;
      5'd6: c.sgn = SGN_APPLY;
      5'd7: begin
        c.a   = A_TMP;
        c.b   = B_ZERO;
        c.sat = 1'b1;
        c.dst = DST_TMP;
      end
      5'd8: begin
        c.a   = A_TMP;
        c.b   = B_SUM;
        c.sat = 1'b1;
        c.dst = DST_SUM;
        c.seq = SEQ_END_IF_MID;
      end
      5'd9: begin
        c.a   = A_LEAK;
        c.b   = B_NVEFF;
        c.dst = DST_TMP;
      end
      5'd10: begin
        c.a   = A_TMP;
        c.b   = B_SUM;
        c.dst = DST_TMP;
      end
      5'd11: begin
        c.a   = A_TMP;
        c.b   = B_DRIVE;
        c.dst = DST_TMP;
      end
      5'd12: c.sgn = SGN_ABS;
      5'd13: c.mul = MUL_TOT_LO;
      5'd14: begin
        c.acc = ACC_LOAD_LO;
        c.mul = MUL_TOT_HI;
      end
      5'd15: c.acc = ACC_ADD_HI;
      5'd16: c.sgn = SGN_APPLY;
      5'd17: begin
        c.a   = A_TMP;
        c.b   = B_VEFF;
        c.sat = 1'b1;
        c.dst = DST_TMP;
      end
      5'd18: begin
        c.emit = 1'b1;
        c.seq  = SEQ_END;
      end
      default: c = CTRL_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/lif_useq.sv
// ----------------------------------------------------------------------------
// lif_useq
// Step counter and control store readout for the neuron core.
// ----------------------------------------------------------------------------
module lif_useq import lif_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  start_last,
  input  logic  hold,
  output logic  busy,
  output ctrl_t ctl
);

  logic [PC_W-1:0] pc;
  logic            last;
  ctrl_t           word;
  logic            stall;

  always_comb begin
    word  = ucode(pc);
    // the result step waits while the output register is still full
    stall = word.emit && hold;
    ctl   = (busy && !stall) ? word : CTRL_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
      last <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= '0;
      last <= start_last;
    end else if (busy && !stall) begin
      case (word.seq)
        SEQ_NEXT: pc <= pc + 5'd1;
        SEQ_END_IF_MID: begin
          if (last) begin
            pc <= pc + 5'd1;
          end else begin
            busy <= 1'b0;
          end
        end
        SEQ_END: busy <= 1'b0;
        default: busy <= 1'b0;
      endcase
    end
  end

endmodule

// File: rtl/lif_dp.sv
// ----------------------------------------------------------------------------
// lif_dp
// Datapath: shared multiplier, accumulator, adder with clamp, neuron state.
// ----------------------------------------------------------------------------
module lif_dp import lif_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [23:0]        in_conductance,
  input  logic signed [31:0] in_reversal,
  input  cfg_t               cfg,
  input  ctrl_t              ctl,
  output res_t               res
);

  localparam logic signed [37:0] WMAX    = 38'sd2147483647;
  localparam logic signed [37:0] WMIN    = -38'sd2147483648;
  localparam logic [36:0]        ACC_CAP = 37'h1000000000;

  logic [23:0]        g;
  logic signed [31:0] vrev;
  logic signed [31:0] veff;
  logic [55:0]        coef;
  logic [63:0]        prod;
  logic [63:0]        acc;
  logic [34:0]        mag;
  logic               neg;
  logic signed [37:0] tmp;
  logic signed [31:0] membrane;
  logic signed [31:0] sum;
  logic [31:0]        ticks;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic signed [37:0] opa;
  logic signed [37:0] opb;
  logic signed [37:0] alu_sum;
  logic signed [37:0] alu_out;
  logic [36:0]        acc_capped;
  logic signed [37:0] acc_signed;
  logic [37:0]        tmp_abs;
  logic signed [31:0] veff_next;
  logic signed [31:0] tmp32;

  always_comb begin
    case (ctl.mul)
      MUL_SCALE_G: begin
        mul_a = cfg.synapse_scale;
        mul_b = {8'd0, g};
      end
      MUL_MAG_LO: begin
        mul_a = mag[31:0];
        mul_b = {8'd0, coef[23:0]};
      end
      MUL_MAG_HI: begin
        mul_a = mag[31:0];
        mul_b = coef[55:24];
      end
      MUL_TOT_LO: begin
        mul_a = mag[31:0];
        mul_b = {8'd0, cfg.step_ratio};
      end
      MUL_TOT_HI: begin
        mul_a = {29'd0, mag[34:32]};
        mul_b = {8'd0, cfg.step_ratio};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_comb begin
    case (ctl.a)
      A_VREV:  opa = 38'(vrev);
      A_LEAK:  opa = 38'(cfg.leak_potential);
      default: opa = tmp;
    endcase
    case (ctl.b)
      B_NVEFF: opb = -38'(veff);
      B_VEFF:  opb = 38'(veff);
      B_SUM:   opb = 38'(sum);
      B_DRIVE: opb = 38'(cfg.drive_voltage);
      default: opb = '0;
    endcase
    alu_sum = opa + opb;
    if (ctl.sat && alu_sum > WMAX) begin
      alu_out = WMAX;
    end else if (ctl.sat && alu_sum < WMIN) begin
      alu_out = WMIN;
    end else begin
      alu_out = alu_sum;
    end
  end

  always_comb begin
    // magnitudes past the 32-bit range all clamp the same way later
    acc_capped = (acc > 64'(ACC_CAP)) ? ACC_CAP : acc[36:0];
    acc_signed = neg ? -$signed({1'b0, acc_capped}) : $signed({1'b0, acc_capped});
    tmp_abs    = tmp[37] ? 38'(-tmp) : 38'(tmp);
    veff_next  = (membrane >= cfg.spike_potential) ? cfg.reset_potential : membrane;
    tmp32      = tmp[31:0];
    res.fired              = tmp32 > cfg.threshold_potential;
    res.membrane_potential = res.fired ? cfg.spike_potential : tmp32;
    res.tick_count         = ticks + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      g    <= in_conductance;
      vrev <= in_reversal;
    end
    if (ctl.veff_ld) begin
      veff <= veff_next;
    end
    prod <= mul_p;
    case (ctl.acc)
      ACC_COEF:    coef <= prod[55:0];
      ACC_LOAD_LO: acc  <= {24'd0, prod[63:24]};
      ACC_ADD:     acc  <= acc + prod;
      ACC_ADD_HI:  acc  <= acc + {prod[55:0], 8'd0};
      default: ;
    endcase
    case (ctl.sgn)
      SGN_ABS: begin
        mag <= tmp_abs[34:0];
        neg <= tmp[37];
      end
      SGN_APPLY: tmp <= acc_signed;
      default: ;
    endcase
    if (ctl.dst == DST_TMP) begin
      tmp <= alu_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      membrane <= MEMBRANE_RESET;
      sum      <= '0;
      ticks    <= '0;
    end else if (ctl.emit) begin
      membrane <= res.membrane_potential;
      sum      <= '0;
      ticks    <= res.tick_count;
    end else if (ctl.dst == DST_SUM) begin
      sum <= alu_out[31:0];
    end
  end

endmodule

// File: rtl/leaky_integrate_fire_neuron_core.sv
// ----------------------------------------------------------------------------
// leaky_integrate_fire_neuron_core
// Conductance-based leaky integrate-and-fire neuron, one Euler step per tick.
// ----------------------------------------------------------------------------
// Each input transfer carries one synapse (conductance in pS, reversal
// potential in Q8.24 volts); tlast marks the final synapse of a tick and
// triggers the membrane update, which yields exactly one output transfer
// (fired flag, new membrane, tick count). Items are handled one at a time by
// a 19-step microprogram driving a single shared 32x32 multiplier: a synapse
// item keeps tready low through steps 0..8, a last item through all 19 steps,
// and also while the result step waits because the previous result still
// sits unaccepted in the output register. The user writes configuration
// through cfg_we/cfg_index/cfg_data only while no item is in flight; the block
// does not enforce this. Unused indexes are ignored. The synaptic sum and the
// membrane saturate to 32-bit signed.
module leaky_integrate_fire_neuron_core import lif_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // synapse stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // conductance [23:0], reversal_potential [55:24]
  input  logic        s_axis_tlast,  // last_synapse
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // fired [0], membrane_potential [32:1],
                                     // tick_count [64:33], zero [71:65]
  // register writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg;
  ctrl_t ctl;
  res_t  res;
  logic  busy;
  logic  in_xfer;
  logic  out_hold;

  // one item in flight; a new synapse is taken once the program is done
  assign s_axis_tready = !busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  // output register still full: the result step must wait
  assign out_hold      = m_axis_tvalid && !m_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leak_potential      <= LEAK_RESET;
      cfg.reset_potential     <= VRESET_RESET;
      cfg.threshold_potential <= THRESHOLD_RESET;
      cfg.spike_potential     <= SPIKE_RESET;
      cfg.step_ratio          <= STEP_RESET;
      cfg.synapse_scale       <= SCALE_RESET;
      cfg.drive_voltage       <= DRIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEAK:      cfg.leak_potential      <= cfg_data;
        CFG_RESET:     cfg.reset_potential     <= cfg_data;
        CFG_THRESHOLD: cfg.threshold_potential <= cfg_data;
        CFG_SPIKE:     cfg.spike_potential     <= cfg_data;
        CFG_STEP:      cfg.step_ratio          <= cfg_data[23:0];
        CFG_SCALE:     cfg.synapse_scale       <= cfg_data;
        CFG_DRIVE:     cfg.drive_voltage       <= cfg_data;
        default: ;
      endcase
    end
  end

  lif_useq u_useq (
    .clk        (clk),
    .rst        (rst),
    .start      (in_xfer),
    .start_last (s_axis_tlast),
    .hold       (out_hold),
    .busy       (busy),
    .ctl        (ctl)
  );

  lif_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .load           (in_xfer),
    .in_conductance (s_axis_tdata[23:0]),
    .in_reversal    (s_axis_tdata[55:24]),
    .cfg            (cfg),
    .ctl            (ctl),
    .res            (res)
  );

  // output register: filled by the result step, emptied by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      m_axis_tdata <= {7'd0, res.tick_count, res.membrane_potential, res.fired};
    end
  end

  // only one item is worked on at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while an item is still in the program");

  // a result must never overwrite one still waiting at the output
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(ctl.emit && out_hold))
    else $error("result step ran while output register was full");

  // every result step shows up at the output
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> m_axis_tvalid)
    else $error("result step did not load the output register");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the leaky integrate-and-fire neuron core.
// ----------------------------------------------------------------------------
// Synapse items are queued by the stimulus process and offered by a clocked
// driver. Every transfer it sees is fed to a local fixed-point predictor of
// the neuron, which queues one expected result per tick. A clocked monitor
// pops those expectations and compares them field by field with each result
// transfer. Registers are rewritten between phases while the core is idle,
// sometimes with a tick left half open, and the random phases cycle through
// patterns of source gaps and sink stalls.
module tb;
  import lif_pkg::*;

  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     SETTLE_CYCLES = 40;    // longer than one tick update
  localparam int     HOLD_CYCLES   = 400;   // long sink hold-off
  localparam longint Q_HI          = 64'sd2147483647;
  localparam longint Q_LO          = -64'sd2147483648;
  localparam logic [63:0] MAG_CAP  = 64'h100_0000_0000;
  // register index past the end of the map, must be ignored
  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef struct {
    logic [23:0] conductance;
    logic [31:0] reversal;
    logic        last;
  } synapse_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;   // conductance [23:0], reversal_potential [55:24]
  logic        s_axis_tlast  = 1'b0; // last_synapse
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // fired [0], membrane_potential [32:1],
                                     // tick_count [64:33], zero [71:65]
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_index     = '0;
  logic [31:0] cfg_data      = '0;

  leaky_integrate_fire_neuron_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // stimulus queue, transfer in flight and expected tick results
  synapse_t pending_synapses[$];
  synapse_t offered_synapse;
  res_t     due_ticks[$];
  int       synapses_queued = 0;
  int       synapses_taken  = 0;
  int       mismatches      = 0;
  int       cycle_count     = 0;

  // idling knobs, changed only between phases
  int       send_idle_pct   = 0;
  int       recv_stall_pct  = 0;
  int       hold_requests   = 0;

  // predictor copy of the registers and the neuron state
  longint      leak_v, vreset_v, thresh_v, spike_v, drive_v;
  longint      step_r, scale_r;
  longint      membrane_v, syn_sum;
  logic [31:0] ticks_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // coef * x / 2^24 truncated toward zero, magnitude capped well past 32 bits
  function automatic longint scale_q24(logic [63:0] coef, longint x);
    logic [63:0] mag, prod;
    mag  = (x < 0) ? 64'(-x) : 64'(x);
    prod = mag * 64'(coef[63:24]) + ((mag * 64'(coef[23:0])) >> 24);
    if (prod > MAG_CAP) prod = MAG_CAP;
    return (x < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      CFG_LEAK:      leak_v   = longint'($signed(val));
      CFG_RESET:     vreset_v = longint'($signed(val));
      CFG_THRESHOLD: thresh_v = longint'($signed(val));
      CFG_SPIKE:     spike_v  = longint'($signed(val));
      CFG_STEP:      step_r   = longint'(val[23:0]);
      CFG_SCALE:     scale_r  = longint'(val);
      CFG_DRIVE:     drive_v  = longint'($signed(val));
      default: ;
    endcase
  endfunction

  // one synapse transfer; the last of a tick runs the euler step
  function automatic void apply_synapse(synapse_t s);
    longint      v, diff, total;
    logic [63:0] coef;
    logic        fired;
    res_t        r;
    // a membrane at spike level starts the tick from the reset potential
    v       = (membrane_v >= spike_v) ? vreset_v : membrane_v;
    coef    = 64'(scale_r) * 64'(s.conductance);
    diff    = clamp_q(longint'($signed(s.reversal)) - v);
    syn_sum = clamp_q(syn_sum + clamp_q(scale_q24(coef, diff)));
    if (!s.last) return;
    total      = (leak_v - v) + syn_sum + drive_v;
    v          = clamp_q(v + scale_q24(64'(step_r), total));
    ticks_seen = ticks_seen + 32'd1;
    fired      = v > thresh_v;
    if (fired) v = spike_v;
    membrane_v = v;
    syn_sum    = 0;
    r.fired              = fired;
    r.membrane_potential = v[31:0];
    r.tick_count         = ticks_seen;
    due_ticks = {due_ticks, r};
  endfunction

  // --------------------------------------------------------------------------
  // synapse driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : synapse_driver
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_synapse(offered_synapse);
        synapses_taken++;
      end
      // a held transfer stays put until taken
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = 1'b0;
        if (pending_synapses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_synapse = pending_synapses.pop_front();
          s_axis_tdata   <= {offered_synapse.reversal, offered_synapse.conductance};
          s_axis_tlast   <= offered_synapse.last;
          offer           = 1'b1;
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor and sink
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : tick_monitor
    int   hold_left;
    int   hold_seen;
    res_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left      = 0;
      hold_seen      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.fired              = m_axis_tdata[0];
        got.membrane_potential = m_axis_tdata[32:1];
        got.tick_count         = m_axis_tdata[64:33];
        if (due_ticks.size() == 0) begin
          $display("%0t: unexpected result transfer, got %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = due_ticks.pop_front();
          if (got.fired !== want.fired) begin
            $display("%0t: fired expected %0d got %0d", $time, want.fired, got.fired);
            mismatches++;
          end
          if (got.membrane_potential !== want.membrane_potential) begin
            $display("%0t: membrane_potential expected %0d got %0d", $time,
                     $signed(want.membrane_potential), $signed(got.membrane_potential));
            mismatches++;
          end
          if (got.tick_count !== want.tick_count) begin
            $display("%0t: tick_count expected %0d got %0d", $time,
                     want.tick_count, got.tick_count);
            mismatches++;
          end
          if (m_axis_tdata[71:65] !== '0) begin
            $display("%0t: pad bits expected 0 got %h", $time, m_axis_tdata[71:65]);
            mismatches++;
          end
        end
      end
      // a new hold request starts a long stretch of back-pressure
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_synapse(logic [23:0] g, logic [31:0] rev, logic last);
    synapse_t s;
    s.conductance = g;
    s.reversal    = rev;
    s.last        = last;
    pending_synapses = {pending_synapses, s};
    synapses_queued++;
  endfunction

  // value spread evenly around a center
  function automatic logic [31:0] near(longint center, int spread);
    return 32'(center + longint'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic void add_random_synapse(logic last);
    logic [23:0] g;
    logic [31:0] rev;
    case ($urandom_range(19))
      0, 1:                g = '0;
      2:                   g = 24'hFF_FFFF;
      3, 4, 5:             g = 24'($urandom);
      6, 7, 8, 9, 10, 11, 12: g = 24'($urandom_range(4095));
      default:             g = 24'($urandom_range(1 << 20));
    endcase
    case ($urandom_range(19))
      0:             rev = 32'h7FFF_FFFF;
      1:             rev = 32'h8000_0000;
      2, 3, 4, 5:    rev = $urandom;
      6, 7, 8, 9:    rev = near(0, 1 << 28);
      default:       rev = near(0, 1677722);   // about +-0.1 V
    endcase
    add_synapse(g, rev, last);
  endfunction

  // a tick: some synapses, then the one that closes it
  function automatic int add_tick();
    int n;
    case ($urandom_range(9))
      0:             n = $urandom_range(10, 16);
      1, 2:          n = $urandom_range(4, 8);
      default:       n = $urandom_range(3);
    endcase
    repeat (n) add_random_synapse(1'b0);
    add_random_synapse(1'b1);
    return n + 1;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_register(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] leak, logic [31:0] vres, logic [31:0] thr,
                           logic [31:0] spk, logic [31:0] step, logic [31:0] scale,
                           logic [31:0] drive);
    write_reg(CFG_LEAK, leak);
    write_reg(CFG_RESET, vres);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_SPIKE, spk);
    write_reg(CFG_STEP, step);
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_DRIVE, drive);
    end_writes();
  endtask

  // near-biological settings, or anything at all when wild
  task automatic write_random_setup(bit wild);
    if (wild) begin
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      write_all(near(-1258291, 167772), near(-1342177, 167772),
                near(-922747, 167772), near(167772, 167772),
                {8'($urandom), 24'($urandom_range(16777, 3355443))},
                32'($urandom_range(20000)), near(335544, 335544));
    end
  endtask

  // sender pause: everything sent, every tick reported, core quiet
  task automatic drain();
    while (synapses_taken != synapses_queued || due_ticks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase_items;
    int target;
    leak_v     = LEAK_RESET;
    vreset_v   = VRESET_RESET;
    thresh_v   = THRESHOLD_RESET;
    spike_v    = SPIKE_RESET;
    step_r     = STEP_RESET;
    scale_r    = SCALE_RESET;
    drive_v    = DRIVE_RESET;
    membrane_v = MEMBRANE_RESET;
    syn_sum    = 0;
    ticks_seen = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset register values: empty tick, field extremes, saturating sums
    add_synapse(24'h00_0000, 32'h0000_0000, 1'b1);
    add_synapse(24'hFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_synapse(24'hFF_FFFF, 32'h8000_0000, 1'b1);
    add_synapse(24'h00_0001, 32'h0000_0001, 1'b0);
    add_synapse(24'h80_0000, 32'hFFFF_FFFF, 1'b1);
    add_synapse(24'h00_0000, 32'h8000_0000, 1'b0);
    add_synapse(24'h00_0FFF, 32'h00D0_0000, 1'b1);
    add_synapse(24'h55_5555, 32'hAAAA_AAAA, 1'b1);
    drain();

    // upper extremes; step written with junk above its 24 bits
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    add_synapse(24'hFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_synapse(24'hFF_FFFF, 32'h8000_0000, 1'b1);
    add_synapse(24'h00_0000, 32'h0000_0000, 1'b1);
    add_synapse(24'h00_0001, 32'h8000_0000, 1'b1);
    add_synapse(24'hFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_synapse(24'h00_3039, 32'h0000_0000, 1'b0);   // tick left open
    drain();

    // lower extremes with the tick still open; spike at the bottom means
    // every tick starts from the reset potential
    write_all(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    add_synapse(24'hFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_synapse(24'hFF_FFFF, 32'h8000_0000, 1'b0);
    add_synapse(24'h00_0000, 32'h0000_0000, 1'b1);
    add_synapse(24'h00_0001, 32'h8000_0000, 1'b1);
    add_synapse(24'hAA_AAAA, 32'h5555_5555, 1'b1);
    drain();

    // the spare index must leave the map untouched
    write_reg(CFG_SPARE, $urandom);
    end_writes();

    // random phases, cycling through the idling patterns
    for (int ph = 0; ph < 12; ph++) begin
      write_random_setup(ph % 3 == 2);
      case (ph % 4)
        0:       set_idling(0, 0);
        1:       set_idling(80, 0);
        2:       set_idling(0, 80);
        default: set_idling(26, 26);
      endcase
      phase_items = 0;
      target      = 105;
      while (phase_items < target) phase_items += add_tick();
      // leave a tick open across the next register rewrite now and then
      if ($urandom_range(1)) repeat ($urandom_range(1, 3)) add_random_synapse(1'b0);
      drain();

      // once, a long sink hold-off while short ticks keep coming
      if (ph == 5) begin
        set_idling(0, 0);
        @(posedge clk);
        hold_requests <= hold_requests + 1;
        repeat (30) begin
          add_random_synapse(1'b0);
          add_random_synapse(1'b1);
        end
        drain();
      end
    end

    drain();
    if (due_ticks.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_ticks.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
